/* sv/icy_md_pkg.sv */
`default_nettype none
package icy_md_pkg;

  // Widths of the stream counters
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned META_W     = 12;
  localparam int unsigned BYTE_W     = 8;

  // Longest title passed on per section
  localparam int unsigned TITLE_MAX  = 255;
  localparam int unsigned TLEN_W     = $clog2(TITLE_MAX + 1);

  // Reset value of the metadata interval register
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(10000);

  // Title prefix StreamTitle='
  localparam int unsigned PREFIX_LEN = 13;
  localparam int unsigned PM_W       = $clog2(PREFIX_LEN + 1);

  localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h27;
  localparam logic [BYTE_W-1:0] CHAR_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CHAR_S     = 8'h53;
  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

  // Title search phase within a metadata section
  localparam logic [1:0] PHASE_SEARCH = 2'd0;
  localparam logic [1:0] PHASE_TITLE  = 2'd1;
  localparam logic [1:0] PHASE_DONE   = 2'd2;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_AUDIO = 2'd0,
    KIND_TITLE = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [BYTE_W-1:0]  data;
    logic               last;
  } result_t;

  // Results produced by one accepted byte
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [BYTE_W-1:0] prefix_char(input logic [PM_W-1:0] idx);
    logic [BYTE_W-1:0] c;
    case (idx)
      4'd0:    c = 8'h53; // S
      4'd1:    c = 8'h74; // t
      4'd2:    c = 8'h72; // r
      4'd3:    c = 8'h65; // e
      4'd4:    c = 8'h61; // a
      4'd5:    c = 8'h6D; // m
      4'd6:    c = 8'h54; // T
      4'd7:    c = 8'h69; // i
      4'd8:    c = 8'h74; // t
      4'd9:    c = 8'h6C; // l
      4'd10:   c = 8'h65; // e
      4'd11:   c = 8'h3D; // =
      4'd12:   c = 8'h27; // '
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* sv/icy_md_in_if.sv */
`default_nettype none
interface icy_md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

/* sv/icy_md_out_if.sv */
`default_nettype none
interface icy_md_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output result_kind, output out_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input result_kind, input out_byte, input last_of_run,
                  output ready);
endinterface
`default_nettype wire

/* sv/icy_metadata_demux.sv */
// Splits an ICY stream into audio and title: one byte is taken per cycle on in_i;
// audio bytes pass to out_o, the length byte and metadata sections are removed, and
// the StreamTitle text of each section comes out as title bytes followed by a
// title-complete transaction. Each byte is handled in the cycle it is accepted and
// may cause zero, one or two results, which wait in a four-entry result queue; a
// byte is accepted whenever the queue has room for two, so the block sustains one
// byte per cycle as long as the sink takes one result per cycle. Title bytes with
// no complete mark (section ended or hit a zero byte) are to be discarded by the
// receiver. Write metadata_interval (reset 10000) only while the block is idle.
`default_nettype none
module icy_metadata_demux
  import icy_md_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [INTERVAL_W-1:0] cfg_wdata_i,
  icy_md_in_if.sink                  in_i,
  icy_md_out_if.source               out_o
);

  push_t   push;
  result_t head;
  logic    room;
  logic    head_valid;
  logic    accept;

  assign in_i.ready = room;
  assign accept     = in_i.valid && room;

  icy_md_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .byte_i      (in_i.data_byte),
    .push_o      (push)
  );

  icy_md_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (head_valid),
    .pop_i   (out_o.ready),
    .head_o  (head)
  );

  // Result channel
  assign out_o.valid       = head_valid;
  assign out_o.result_kind = head.kind;
  assign out_o.out_byte    = head.data;
  assign out_o.last_of_run = head.last;

endmodule
`default_nettype wire

/* sv/icy_md_parse.sv */
`default_nettype none
module icy_md_parse
  import icy_md_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [INTERVAL_W-1:0] cfg_wdata_i,
  input  wire logic                  accept_i,
  input  wire logic [BYTE_W-1:0]     byte_i,
  output push_t                      push_o
);

  logic [INTERVAL_W-1:0] interval_q;
  logic [INTERVAL_W-1:0] audio_cnt_q, audio_cnt_d;
  logic [META_W-1:0]     meta_len_q, meta_len_d;
  logic [META_W-1:0]     meta_pos_q, meta_pos_d;
  logic [PM_W-1:0]       pm_cnt_q, pm_cnt_d;
  logic [1:0]            phase_q, phase_d;
  logic                  quote_q, quote_d;
  logic [TLEN_W-1:0]     tlen_q, tlen_d;

  logic [1:0]            n;
  result_t               r0, r1;
  logic                  ok1, ok2;
  logic [TLEN_W-1:0]     tlen1;
  logic [PM_W-1:0]       pm_next;

  // Interval register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= INTERVAL_RESET;
    end else if (cfg_we_i) begin
      interval_q <= cfg_wdata_i;
    end
  end

  // Next state and results for one byte
  always_comb begin
    audio_cnt_d = audio_cnt_q;
    meta_len_d  = meta_len_q;
    meta_pos_d  = meta_pos_q;
    pm_cnt_d    = pm_cnt_q;
    phase_d     = phase_q;
    quote_d     = quote_q;
    tlen_d      = tlen_q;
    n           = 2'd0;
    r0          = '{kind: KIND_AUDIO, data: byte_i, last: 1'b0};
    r1          = '{kind: KIND_TITLE, data: byte_i, last: 1'b0};
    ok1         = 1'b0;
    ok2         = 1'b0;
    tlen1       = tlen_q;
    pm_next     = '0;

    if (meta_len_q != '0) begin
      meta_pos_d = meta_pos_q + META_W'(1);
      if (phase_q != PHASE_DONE) begin
        if (byte_i == CHAR_NUL) begin
          phase_d = PHASE_DONE;
          quote_d = 1'b0;
        end else if (phase_q == PHASE_SEARCH) begin
          // prefix matcher, restarts on S
          if (pm_cnt_q < PM_W'(PREFIX_LEN) && byte_i == prefix_char(pm_cnt_q)) begin
            pm_next = pm_cnt_q + PM_W'(1);
          end else begin
            pm_next = (byte_i == CHAR_S) ? PM_W'(1) : '0;
          end
          pm_cnt_d = pm_next;
          if (pm_next >= PM_W'(PREFIX_LEN)) begin
            phase_d = PHASE_TITLE;
            quote_d = 1'b0;
            tlen_d  = '0;
          end
        end else if (quote_q) begin
          if (byte_i == CHAR_SEMI) begin
            // end of title
            quote_d = 1'b0;
            phase_d = PHASE_DONE;
            n       = 2'd1;
            r0      = '{kind: KIND_DONE, data: '0, last: 1'b0};
          end else begin
            // release the held quote, then possibly this byte
            ok1   = (tlen_q < TLEN_W'(TITLE_MAX));
            tlen1 = tlen_q + TLEN_W'(ok1);
            r0    = '{kind: KIND_TITLE, data: CHAR_QUOTE, last: 1'b0};
            if (byte_i != CHAR_QUOTE) begin
              quote_d = 1'b0;
              ok2     = (tlen1 < TLEN_W'(TITLE_MAX));
              tlen_d  = tlen1 + TLEN_W'(ok2);
              if (!ok1) begin
                r0 = '{kind: KIND_TITLE, data: byte_i, last: 1'b0};
              end
            end else begin
              tlen_d = tlen1;
            end
            n = 2'({1'b0, ok1}) + 2'({1'b0, ok2});
          end
        end else if (byte_i == CHAR_QUOTE) begin
          quote_d = 1'b1;
        end else if (tlen_q < TLEN_W'(TITLE_MAX)) begin
          tlen_d = tlen_q + TLEN_W'(1);
          n      = 2'd1;
          r0     = '{kind: KIND_TITLE, data: byte_i, last: 1'b0};
        end
      end
      if (meta_pos_d == meta_len_q) begin
        meta_len_d = '0;
      end
    end else if (audio_cnt_q < interval_q) begin
      audio_cnt_d = audio_cnt_q + INTERVAL_W'(1);
      n           = 2'd1;
      r0          = '{kind: KIND_AUDIO, data: byte_i, last: 1'b0};
    end else begin
      // length byte opens a section of 16 * byte
      audio_cnt_d = '0;
      meta_len_d  = {byte_i, 4'b0000};
      meta_pos_d  = '0;
      pm_cnt_d    = '0;
      phase_d     = PHASE_SEARCH;
      quote_d     = 1'b0;
      tlen_d      = '0;
    end

    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      audio_cnt_q <= '0;
      meta_len_q  <= '0;
      meta_pos_q  <= '0;
      pm_cnt_q    <= '0;
      phase_q     <= PHASE_SEARCH;
      quote_q     <= 1'b0;
      tlen_q      <= '0;
    end else if (accept_i) begin
      audio_cnt_q <= audio_cnt_d;
      meta_len_q  <= meta_len_d;
      meta_pos_q  <= meta_pos_d;
      pm_cnt_q    <= pm_cnt_d;
      phase_q     <= phase_d;
      quote_q     <= quote_d;
      tlen_q      <= tlen_d;
    end
  end

  assign push_o = '{count: (accept_i ? n : 2'd0), r0: r0, r1: r1};

endmodule
`default_nettype wire

/* sv/icy_md_queue.sv */
`default_nettype none
module icy_md_queue
  import icy_md_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  output logic       room_o,
  output logic       valid_o,
  input  wire logic  pop_i,
  output result_t    head_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  result_t           mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              pop;

  assign pop     = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  // space for the two results one byte can cause
  assign room_o  = (cnt_q <= CNT_W'(DEPTH - 2));

  // Result storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= push_i.r1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_i.count);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      cnt_q    <= cnt_q + CNT_W'(push_i.count) - CNT_W'(pop);
    end
  end

endmodule
`default_nettype wire
